/* design/weighted_histogram_fill_macros.svh */
// ----------------------------------------------------------------------------
// Weighted histogram fill: assertion macros
// Short forms for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_HISTOGRAM_FILL_MACROS_SVH
`define WEIGHTED_HISTOGRAM_FILL_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WHF_ASSERT_SAME(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("weighted histogram check failed");

// Consequent must hold in the cycle after the antecedent.
`define WHF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("weighted histogram check failed");

`endif

/* design/whf_pkg.sv */
// ----------------------------------------------------------------------------
// Weighted histogram fill: package
// Sizes, codes, state types and shared structs of the histogram block.
// ----------------------------------------------------------------------------
package whf_pkg;

	localparam int NUM_BINS = 1024;
	localparam int BIN_AW   = $clog2(NUM_BINS);
	localparam int SUM_W    = 48;
	localparam int DATA_W   = 32;
	localparam int NB_W     = 11;
	localparam int IDX_W    = 10;
	localparam int KIND_W   = 2;
	localparam int MODE_W   = 2;
	localparam int CNT_W    = 32;
	localparam int CFG_IW   = 2;
	localparam int PROD_W   = DATA_W + NB_W;
	localparam int STEP_CW  = $clog2(BIN_AW);

	localparam logic [MODE_W-1:0] MODE_FILL  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	localparam logic [KIND_W-1:0] KIND_IN    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_UNDER = 2'd1;
	localparam logic [KIND_W-1:0] KIND_OVER  = 2'd2;

	localparam logic [CFG_IW-1:0] CFG_RANGE_LOW   = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_RANGE_HIGH  = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_BINS_IN_USE = 2'd2;

	localparam logic signed [DATA_W-1:0] RANGE_LOW_RST  = 32'sd0;
	localparam logic signed [DATA_W-1:0] RANGE_HIGH_RST = 32'sd16777216;
	localparam logic [NB_W-1:0]          BINS_RST       = 11'd1024;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_DIVIDE,
		ST_MEM_RD,
		ST_MEM_WAIT,
		ST_CLEAR_WAIT,
		ST_RESULT
	} seq_state_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_LOAD,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

	typedef struct packed {
		logic                     clear;
		logic                     rd_en;
		logic                     add_en;
		logic [BIN_AW-1:0]        addr;
		logic signed [DATA_W-1:0] weight;
	} store_req_t;

	typedef struct packed {
		logic                    busy;
		logic                    done;
		logic signed [SUM_W-1:0] value;
	} store_rsp_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == '1) ? c : c + CNT_W'(1);
	endfunction

endpackage

/* design/whf_if.sv */
// ----------------------------------------------------------------------------
// Weighted histogram fill: channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface whf_req_if;
	logic                                    valid;
	logic                                    ready;
	logic [whf_pkg::MODE_W-1:0]              mode;
	logic signed [whf_pkg::DATA_W-1:0]       sample;
	logic signed [whf_pkg::DATA_W-1:0]       weight;
	logic [whf_pkg::IDX_W-1:0]               read_index;

	modport source(output valid, mode, sample, weight, read_index, input ready);
	modport sink(input valid, mode, sample, weight, read_index, output ready);
endinterface

interface whf_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [whf_pkg::IDX_W-1:0]           bin_index;
	logic [whf_pkg::KIND_W-1:0]          hit_kind;
	logic signed [whf_pkg::SUM_W-1:0]    bin_value;
	logic [whf_pkg::CNT_W-1:0]           entry_count;
	logic [whf_pkg::CNT_W-1:0]           underflow_count;
	logic [whf_pkg::CNT_W-1:0]           overflow_count;

	modport source(output valid, bin_index, hit_kind, bin_value, entry_count,
		underflow_count, overflow_count, input ready);
	modport sink(input valid, bin_index, hit_kind, bin_value, entry_count,
		underflow_count, overflow_count, output ready);
endinterface

interface whf_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [whf_pkg::CFG_IW-1:0]   index;
	logic [whf_pkg::DATA_W-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* design/whf_divider.sv */
// ----------------------------------------------------------------------------
// Weighted histogram fill: bin divider
// Computes floor(offset * nb / span) one quotient bit per cycle.
// ----------------------------------------------------------------------------
module whf_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [whf_pkg::DATA_W-1:0]    offset,
	input  logic [whf_pkg::DATA_W-1:0]    span,
	input  logic [whf_pkg::NB_W-1:0]      nb,
	output logic                          done,
	output logic [whf_pkg::BIN_AW-1:0]    quotient
);

	whf_pkg::div_state_t                 state_q;
	whf_pkg::div_state_t                 state_d;
	logic [whf_pkg::PROD_W-1:0]          prod_q;
	logic [whf_pkg::DATA_W-1:0]          span_q;
	logic [whf_pkg::DATA_W-1:0]          rem_q;
	logic [whf_pkg::BIN_AW-1:0]          quo_q;
	logic [whf_pkg::STEP_CW-1:0]         cnt_q;
	logic [whf_pkg::DATA_W:0]            trial;
	logic [whf_pkg::DATA_W:0]            trial_sub;
	logic                                fits;

	// The quotient is below nb, so the top of the product is already below span.
	assign trial     = {rem_q, quo_q[whf_pkg::BIN_AW-1]};
	assign trial_sub = trial - {1'b0, span_q};
	assign fits      = trial >= {1'b0, span_q};
	assign quotient  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= whf_pkg::DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		unique case (state_q)
			whf_pkg::DIV_IDLE: begin
				if (start) begin
					state_d = whf_pkg::DIV_LOAD;
				end
			end
			whf_pkg::DIV_LOAD: begin
				state_d = whf_pkg::DIV_RUN;
			end
			whf_pkg::DIV_RUN: begin
				if (cnt_q == whf_pkg::STEP_CW'(whf_pkg::BIN_AW - 1)) begin
					state_d = whf_pkg::DIV_DONE;
				end
			end
			whf_pkg::DIV_DONE: begin
				done    = 1'b1;
				state_d = whf_pkg::DIV_IDLE;
			end
			default: begin
				state_d = whf_pkg::DIV_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == whf_pkg::DIV_LOAD) begin
			cnt_q <= '0;
		end else if (state_q == whf_pkg::DIV_RUN) begin
			cnt_q <= cnt_q + whf_pkg::STEP_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == whf_pkg::DIV_IDLE && start) begin
			prod_q <= {{whf_pkg::NB_W{1'b0}}, offset} * {{whf_pkg::DATA_W{1'b0}}, nb};
			span_q <= span;
		end
		if (state_q == whf_pkg::DIV_LOAD) begin
			rem_q <= prod_q[whf_pkg::BIN_AW +: whf_pkg::DATA_W];
			quo_q <= prod_q[whf_pkg::BIN_AW-1:0];
		end else if (state_q == whf_pkg::DIV_RUN) begin
			rem_q <= fits ? trial_sub[whf_pkg::DATA_W-1:0] : trial[whf_pkg::DATA_W-1:0];
			quo_q <= {quo_q[whf_pkg::BIN_AW-2:0], fits};
		end
	end

endmodule

/* design/whf_bin_store.sv */
// ----------------------------------------------------------------------------
// Weighted histogram fill: bin store
// Bin accumulator memory with saturating read-modify-write and a clear sweep.
// ----------------------------------------------------------------------------
module whf_bin_store (
	input  logic                  clk,
	input  logic                  arst_n,
	input  whf_pkg::store_req_t   req,
	output whf_pkg::store_rsp_t   rsp
);

	localparam logic signed [whf_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(whf_pkg::SUM_W-1){1'b1}}};
	localparam logic signed [whf_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(whf_pkg::SUM_W-1){1'b0}}};

	logic signed [whf_pkg::SUM_W-1:0]  mem [whf_pkg::NUM_BINS];
	logic                              clr_busy_q;
	logic [whf_pkg::BIN_AW-1:0]        clr_addr_q;
	logic                              op_valid_s1;
	logic                              op_add_s1;
	logic [whf_pkg::BIN_AW-1:0]        addr_s1;
	logic signed [whf_pkg::DATA_W-1:0] weight_s1;
	logic signed [whf_pkg::SUM_W-1:0]  rdata_s1;
	logic [whf_pkg::SUM_W:0]           sum;
	logic signed [whf_pkg::SUM_W-1:0]  sat_val;
	logic                              wr_en;
	logic [whf_pkg::BIN_AW-1:0]        wr_addr;
	logic signed [whf_pkg::SUM_W-1:0]  wr_data;

	assign sum = {rdata_s1[whf_pkg::SUM_W-1], rdata_s1}
		+ {{(whf_pkg::SUM_W + 1 - whf_pkg::DATA_W){weight_s1[whf_pkg::DATA_W-1]}}, weight_s1};

	always_comb begin
		if (sum[whf_pkg::SUM_W] != sum[whf_pkg::SUM_W-1]) begin
			sat_val = sum[whf_pkg::SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sat_val = sum[whf_pkg::SUM_W-1:0];
		end
	end

	assign wr_en   = clr_busy_q || (op_valid_s1 && op_add_s1);
	assign wr_addr = clr_busy_q ? clr_addr_q : addr_s1;
	assign wr_data = clr_busy_q ? '0 : sat_val;

	assign rsp.busy  = clr_busy_q;
	assign rsp.done  = op_valid_s1;
	assign rsp.value = op_add_s1 ? sat_val : rdata_s1;

	// The store starts with a clearing pass, so it reads as zero after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			op_valid_s1 <= 1'b0;
			op_add_s1   <= 1'b0;
		end else begin
			if (req.clear) begin
				clr_busy_q <= 1'b1;
				clr_addr_q <= '0;
			end else if (clr_busy_q) begin
				if (clr_addr_q == whf_pkg::BIN_AW'(whf_pkg::NUM_BINS - 1)) begin
					clr_busy_q <= 1'b0;
				end
				clr_addr_q <= clr_addr_q + whf_pkg::BIN_AW'(1);
			end
			op_valid_s1 <= req.rd_en;
			op_add_s1   <= req.rd_en && req.add_en;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			addr_s1   <= req.addr;
			weight_s1 <= req.weight;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (req.rd_en) begin
			rdata_s1 <= mem[req.addr];
		end
	end

endmodule

/* design/weighted_histogram_fill.sv */
// ----------------------------------------------------------------------------
// Weighted histogram fill: top level
// Fixed-width bin histogram with weighted fills, bin reads and a full clear.
// ----------------------------------------------------------------------------
// The block handles one item at a time. A fill that lands inside the range
// spends most of its time in the bin divider, which produces one quotient
// bit per cycle over ten steps; the bin itself is then read, updated and
// written back through the accumulator memory. A fill below or above the
// range answers without the divider or the memory, a fill with an empty
// range goes to the first bin without the divider, and a bin read goes
// straight to the memory. A clear sweeps the memory one bin per cycle.
// After reset the same clearing pass runs, and no item is accepted
// until it ends; configuration writes are taken at any time. A finished
// result waits in the output register while the next item is accepted.
module weighted_histogram_fill (
	input  logic      clk,
	input  logic      arst_n,
	whf_req_if.sink   req,
	whf_rsp_if.source rsp,
	whf_cfg_if.sink   cfg
);

	whf_pkg::seq_state_t                 state_q;
	whf_pkg::seq_state_t                 state_d;
	logic signed [whf_pkg::DATA_W-1:0]   range_low_q;
	logic signed [whf_pkg::DATA_W-1:0]   range_high_q;
	logic [whf_pkg::NB_W-1:0]            bins_q;
	logic [whf_pkg::NB_W-1:0]            nb_eff;
	logic [whf_pkg::MODE_W-1:0]          mode_q;
	logic signed [whf_pkg::DATA_W-1:0]   sample_q;
	logic signed [whf_pkg::DATA_W-1:0]   weight_q;
	logic                                rd_oob_q;
	logic [whf_pkg::IDX_W-1:0]           res_idx_q;
	logic [whf_pkg::KIND_W-1:0]          res_kind_q;
	logic signed [whf_pkg::SUM_W-1:0]    res_val_q;
	logic [whf_pkg::CNT_W-1:0]           fills_q;
	logic [whf_pkg::CNT_W-1:0]           below_q;
	logic [whf_pkg::CNT_W-1:0]           above_q;
	logic                                rsp_valid_q;
	logic [whf_pkg::IDX_W-1:0]           out_idx_q;
	logic [whf_pkg::KIND_W-1:0]          out_kind_q;
	logic signed [whf_pkg::SUM_W-1:0]    out_val_q;
	logic [whf_pkg::CNT_W-1:0]           out_fills_q;
	logic [whf_pkg::CNT_W-1:0]           out_below_q;
	logic [whf_pkg::CNT_W-1:0]           out_above_q;
	logic                                req_ready;
	logic                                req_acc;
	logic                                out_free;
	logic signed [whf_pkg::DATA_W:0]     span;
	logic signed [whf_pkg::DATA_W:0]     offset;
	logic                                empty_range;
	logic                                is_under;
	logic                                is_over;
	logic                                div_start;
	logic                                div_done;
	logic [whf_pkg::BIN_AW-1:0]          div_quo;
	whf_pkg::store_req_t                 st_req;
	whf_pkg::store_rsp_t                 st_rsp;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= whf_pkg::RANGE_LOW_RST;
			range_high_q <= whf_pkg::RANGE_HIGH_RST;
			bins_q       <= whf_pkg::BINS_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				whf_pkg::CFG_RANGE_LOW:   range_low_q  <= cfg.data;
				whf_pkg::CFG_RANGE_HIGH:  range_high_q <= cfg.data;
				whf_pkg::CFG_BINS_IN_USE: bins_q       <= cfg.data[whf_pkg::NB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign nb_eff = (bins_q == '0) ? whf_pkg::NB_W'(1)
		: (bins_q > whf_pkg::NB_W'(whf_pkg::NUM_BINS)) ? whf_pkg::NB_W'(whf_pkg::NUM_BINS)
		: bins_q;

	assign span   = {range_high_q[whf_pkg::DATA_W-1], range_high_q}
		- {range_low_q[whf_pkg::DATA_W-1], range_low_q};
	assign offset = {sample_q[whf_pkg::DATA_W-1], sample_q}
		- {range_low_q[whf_pkg::DATA_W-1], range_low_q};

	// With an empty range every sample goes to the first bin.
	assign empty_range = span[whf_pkg::DATA_W] || (span == '0);
	assign is_under    = !empty_range && offset[whf_pkg::DATA_W];
	assign is_over     = !empty_range && !offset[whf_pkg::DATA_W]
		&& (offset[whf_pkg::DATA_W-1:0] >= span[whf_pkg::DATA_W-1:0]);

	assign req.ready = req_ready;
	assign req_acc   = req.valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= whf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		req_ready     = 1'b0;
		div_start     = 1'b0;
		st_req.clear  = 1'b0;
		st_req.rd_en  = 1'b0;
		st_req.add_en = 1'b0;
		st_req.addr   = res_idx_q[whf_pkg::BIN_AW-1:0];
		st_req.weight = weight_q;
		unique case (state_q)
			whf_pkg::ST_IDLE: begin
				req_ready = !st_rsp.busy;
				if (req.valid && !st_rsp.busy) begin
					unique case (req.mode)
						whf_pkg::MODE_FILL: begin
							state_d = whf_pkg::ST_CLASSIFY;
						end
						whf_pkg::MODE_CLEAR: begin
							st_req.clear = 1'b1;
							state_d      = whf_pkg::ST_CLEAR_WAIT;
						end
						default: begin
							state_d = whf_pkg::ST_MEM_RD;
						end
					endcase
				end
			end
			whf_pkg::ST_CLASSIFY: begin
				if (empty_range) begin
					state_d = whf_pkg::ST_MEM_RD;
				end else if (is_under || is_over) begin
					state_d = whf_pkg::ST_RESULT;
				end else begin
					div_start = 1'b1;
					state_d   = whf_pkg::ST_DIVIDE;
				end
			end
			whf_pkg::ST_DIVIDE: begin
				if (div_done) begin
					state_d = whf_pkg::ST_MEM_RD;
				end
			end
			whf_pkg::ST_MEM_RD: begin
				st_req.rd_en  = 1'b1;
				st_req.add_en = (mode_q == whf_pkg::MODE_FILL);
				state_d       = whf_pkg::ST_MEM_WAIT;
			end
			whf_pkg::ST_MEM_WAIT: begin
				if (st_rsp.done) begin
					state_d = whf_pkg::ST_RESULT;
				end
			end
			whf_pkg::ST_CLEAR_WAIT: begin
				if (!st_rsp.busy) begin
					state_d = whf_pkg::ST_RESULT;
				end
			end
			whf_pkg::ST_RESULT: begin
				if (out_free) begin
					state_d = whf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = whf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fills_q <= '0;
			below_q <= '0;
			above_q <= '0;
		end else if (req_acc && req.mode == whf_pkg::MODE_CLEAR) begin
			fills_q <= '0;
			below_q <= '0;
			above_q <= '0;
		end else if (state_q == whf_pkg::ST_CLASSIFY) begin
			fills_q <= whf_pkg::sat_inc(fills_q);
			if (is_under) begin
				below_q <= whf_pkg::sat_inc(below_q);
			end else if (is_over) begin
				above_q <= whf_pkg::sat_inc(above_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			mode_q     <= req.mode;
			sample_q   <= req.sample;
			weight_q   <= req.weight;
			res_idx_q  <= (req.mode == whf_pkg::MODE_CLEAR) ? '0 : req.read_index;
			res_kind_q <= whf_pkg::KIND_IN;
			res_val_q  <= '0;
			rd_oob_q   <= (req.mode != whf_pkg::MODE_FILL)
				&& ({1'b0, req.read_index} >= (whf_pkg::IDX_W + 1)'(whf_pkg::NUM_BINS));
		end
		if (state_q == whf_pkg::ST_CLASSIFY) begin
			res_idx_q  <= '0;
			res_kind_q <= is_under ? whf_pkg::KIND_UNDER
				: is_over ? whf_pkg::KIND_OVER : whf_pkg::KIND_IN;
		end
		if (state_q == whf_pkg::ST_DIVIDE && div_done) begin
			res_idx_q <= whf_pkg::IDX_W'(div_quo);
		end
		if (state_q == whf_pkg::ST_MEM_WAIT && st_rsp.done) begin
			res_val_q <= rd_oob_q ? '0 : st_rsp.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == whf_pkg::ST_RESULT && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == whf_pkg::ST_RESULT && out_free) begin
			out_idx_q   <= res_idx_q;
			out_kind_q  <= res_kind_q;
			out_val_q   <= res_val_q;
			out_fills_q <= fills_q;
			out_below_q <= below_q;
			out_above_q <= above_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.bin_index       = out_idx_q;
	assign rsp.hit_kind        = out_kind_q;
	assign rsp.bin_value       = out_val_q;
	assign rsp.entry_count     = out_fills_q;
	assign rsp.underflow_count = out_below_q;
	assign rsp.overflow_count  = out_above_q;

	whf_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.offset   (offset[whf_pkg::DATA_W-1:0]),
		.span     (span[whf_pkg::DATA_W-1:0]),
		.nb       (nb_eff),
		.done     (div_done),
		.quotient (div_quo)
	);

	whf_bin_store u_bin_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (st_req),
		.rsp    (st_rsp)
	);

endmodule

/* design/whf_checker.sv */
// ----------------------------------------------------------------------------
// Weighted histogram fill: port checker
// Checks the result channel of the histogram block over time.
// ----------------------------------------------------------------------------
`include "weighted_histogram_fill_macros.svh"

module whf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic [whf_pkg::IDX_W-1:0]        bin_index,
	input logic [whf_pkg::KIND_W-1:0]       hit_kind,
	input logic signed [whf_pkg::SUM_W-1:0] bin_value,
	input logic [whf_pkg::CNT_W-1:0]        entry_count,
	input logic [whf_pkg::CNT_W-1:0]        underflow_count,
	input logic [whf_pkg::CNT_W-1:0]        overflow_count
);

	logic [whf_pkg::CNT_W-1:0] last_entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_entry_q <= '0;
		end else if (rsp_valid && rsp_ready) begin
			last_entry_q <= entry_count;
		end
	end

	`WHF_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(bin_value) && $stable(entry_count) && $stable(bin_index))

	`WHF_ASSERT_SAME(a_out_of_range_zero, clk, arst_n, rsp_valid && (hit_kind == whf_pkg::KIND_UNDER || hit_kind == whf_pkg::KIND_OVER), bin_index == '0 && bin_value == '0)

	`WHF_ASSERT_SAME(a_count_bound, clk, arst_n, rsp_valid, underflow_count <= entry_count && overflow_count <= entry_count)

	`WHF_ASSERT_SAME(a_count_order, clk, arst_n, rsp_valid && rsp_ready, entry_count >= last_entry_q || (entry_count == '0 && underflow_count == '0 && overflow_count == '0))

endmodule

bind weighted_histogram_fill whf_checker u_whf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.bin_index       (rsp.bin_index),
	.hit_kind        (rsp.hit_kind),
	.bin_value       (rsp.bin_value),
	.entry_count     (rsp.entry_count),
	.underflow_count (rsp.underflow_count),
	.overflow_count  (rsp.overflow_count)
);
